// ===== design/cdq_pkg.sv =====
// ---------------------------------------------------------------------------
// cdq_pkg
// Shared sizes, codes and bundles of the circular deque.
// ---------------------------------------------------------------------------
package cdq_pkg;

   localparam int DEPTH    = 16;
   localparam int IDX_W    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W    = $clog2(DEPTH + 1);
   localparam int WORD_W   = 32;
   localparam int FILL_W   = 5;

   localparam logic [IDX_W-1:0] LAST_IDX  = IDX_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] FULL_CNT  = CNT_W'(DEPTH);

   typedef enum logic [1:0] {
      FN_PUSH_BACK  = 2'd0,
      FN_PUSH_FRONT = 2'd1,
      FN_POP_FRONT  = 2'd2,
      FN_POP_BACK   = 2'd3
   } cdq_func_type;

   typedef enum logic [1:0] {
      ST_DONE      = 2'd0,
      ST_OVERFLOW  = 2'd1,
      ST_UNDERFLOW = 2'd2
   } cdq_status_type;

   typedef struct packed {
      logic              wr_en;
      logic [IDX_W-1:0]  wr_addr;
      logic [WORD_W-1:0] wr_data;
      logic              rd_en;
      logic [IDX_W-1:0]  rd_addr;
   } cdq_mem_req_type;

   typedef struct packed {
      cdq_status_type    status;
      logic [FILL_W-1:0] fill_count;
      logic              is_empty;
      logic              is_full;
      logic [WORD_W-1:0] front_word;
      logic [WORD_W-1:0] rear_word;
   } cdq_result_type;

   function automatic logic [IDX_W-1:0] idx_up(input logic [IDX_W-1:0] i);
      return (i == LAST_IDX) ? '0 : i + 1'b1;
   endfunction

   function automatic logic [IDX_W-1:0] idx_down(input logic [IDX_W-1:0] i);
      return (i == '0) ? LAST_IDX : i - 1'b1;
   endfunction

   function automatic logic [FILL_W-1:0] to_fill(input logic [CNT_W-1:0] c);
      logic [CNT_W+FILL_W-1:0] wide;
      wide = (CNT_W + FILL_W)'(c);
      return wide[FILL_W-1:0];
   endfunction

endpackage

// ===== design/cdq_ram.sv =====
// ---------------------------------------------------------------------------
// cdq_ram
// Simple dual-port synchronous RAM, one write and one registered read port.
// ---------------------------------------------------------------------------
module cdq_ram #(
   parameter int WIDTH  = 32,
   parameter int DEPTH  = 16,
   parameter int ADDR_W = 4
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== design/cdq_ctrl.sv =====
// ---------------------------------------------------------------------------
// cdq_ctrl
// Index, count and end-word tracking; drives the ring RAM and the result.
// ---------------------------------------------------------------------------
module cdq_ctrl (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_stall,
   input  logic [1:0]                   req_func,
   input  logic [cdq_pkg::WORD_W-1:0]   req_value,
   output cdq_pkg::cdq_mem_req_type     mem_req,
   input  logic [cdq_pkg::WORD_W-1:0]   mem_rd_data,
   output logic                         res_valid,
   output cdq_pkg::cdq_result_type      res,
   input  logic                         res_free
);
   import cdq_pkg::*;

   typedef enum logic [1:0] {
      S_IDLE,
      S_FETCH,
      S_SEND
   } state_type;

   state_type          state_ff, state_in;
   logic [IDX_W-1:0]   head_ff, head_in;
   logic [IDX_W-1:0]   tail_ff, tail_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic [WORD_W-1:0]  front_ff, front_in;
   logic [WORD_W-1:0]  rear_ff, rear_in;
   cdq_status_type     status_ff, status_in;
   logic               pend_front_ff, pend_front_in;

   logic               accept;
   logic               empty;
   logic               full;
   cdq_func_type       func;

   assign accept = req_valid && (state_ff == S_IDLE);
   assign req_stall = (state_ff != S_IDLE);
   assign empty = (count_ff == '0);
   assign full = (count_ff == FULL_CNT);
   assign func = cdq_func_type'(req_func);

   always_comb begin
      state_in      = state_ff;
      head_in       = head_ff;
      tail_in       = tail_ff;
      count_in      = count_ff;
      front_in      = front_ff;
      rear_in       = rear_ff;
      status_in     = status_ff;
      pend_front_in = pend_front_ff;
      mem_req       = '0;
      mem_req.wr_data = req_value;

      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               status_in = ST_DONE;
               state_in  = S_SEND;
               case (func)
                  FN_PUSH_BACK, FN_PUSH_FRONT: begin
                     if (full) begin
                        status_in = ST_OVERFLOW;
                     end else if (empty) begin
                        head_in         = '0;
                        tail_in         = '0;
                        count_in        = CNT_W'(1);
                        front_in        = req_value;
                        rear_in         = req_value;
                        mem_req.wr_en   = 1'b1;
                        mem_req.wr_addr = '0;
                     end else if (func == FN_PUSH_BACK) begin
                        tail_in         = idx_up(tail_ff);
                        count_in        = count_ff + 1'b1;
                        rear_in         = req_value;
                        mem_req.wr_en   = 1'b1;
                        mem_req.wr_addr = idx_up(tail_ff);
                     end else begin
                        head_in         = idx_down(head_ff);
                        count_in        = count_ff + 1'b1;
                        front_in        = req_value;
                        mem_req.wr_en   = 1'b1;
                        mem_req.wr_addr = idx_down(head_ff);
                     end
                  end
                  FN_POP_FRONT, FN_POP_BACK: begin
                     if (empty) begin
                        status_in = ST_UNDERFLOW;
                     end else if (count_ff == CNT_W'(1)) begin
                        head_in  = '0;
                        tail_in  = '0;
                        count_in = '0;
                     end else if (func == FN_POP_FRONT) begin
                        head_in         = idx_up(head_ff);
                        count_in        = count_ff - 1'b1;
                        mem_req.rd_en   = 1'b1;
                        mem_req.rd_addr = idx_up(head_ff);
                        pend_front_in   = 1'b1;
                        state_in        = S_FETCH;
                     end else begin
                        tail_in         = idx_down(tail_ff);
                        count_in        = count_ff - 1'b1;
                        mem_req.rd_en   = 1'b1;
                        mem_req.rd_addr = idx_down(tail_ff);
                        pend_front_in   = 1'b0;
                        state_in        = S_FETCH;
                     end
                  end
                  default: begin
                     state_in = S_SEND;
                  end
               endcase
            end
         end
         S_FETCH: begin
            if (pend_front_ff) begin
               front_in = mem_rd_data;
            end else begin
               rear_in = mem_rd_data;
            end
            state_in = S_SEND;
         end
         S_SEND: begin
            if (res_free) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         head_ff       <= '0;
         tail_ff       <= '0;
         count_ff      <= '0;
         status_ff     <= ST_DONE;
         pend_front_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         head_ff       <= head_in;
         tail_ff       <= tail_in;
         count_ff      <= count_in;
         status_ff     <= status_in;
         pend_front_ff <= pend_front_in;
      end
      front_ff <= front_in;
      rear_ff  <= rear_in;
   end

   // end words read as zero once the deque is empty
   assign res_valid      = (state_ff == S_SEND);
   assign res.status     = status_ff;
   assign res.fill_count = to_fill(count_ff);
   assign res.is_empty   = empty;
   assign res.is_full    = full;
   assign res.front_word = empty ? '0 : front_ff;
   assign res.rear_word  = empty ? '0 : rear_ff;

endmodule

// ===== design/cdq_out.sv =====
// ---------------------------------------------------------------------------
// cdq_out
// Output register of the result channel.
// ---------------------------------------------------------------------------
module cdq_out (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       res_valid,
   input  cdq_pkg::cdq_result_type    res,
   output logic                       res_free,
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output cdq_pkg::cdq_result_type    rsp_beat
);
   import cdq_pkg::*;

   logic           valid_ff;
   cdq_result_type beat_ff;

   assign res_free = !valid_ff || !rsp_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (res_free) begin
         valid_ff <= res_valid;
      end
      if (res_free && res_valid) begin
         beat_ff <= res;
      end
   end

   assign rsp_valid = valid_ff;
   assign rsp_beat  = beat_ff;

endmodule

// ===== design/circular_deque.sv =====
// ---------------------------------------------------------------------------
// circular_deque
// Double-ended queue of 32-bit words in a ring RAM of DEPTH entries.
// Order: a push, a rejected op or a pop of the last word goes IDLE, SEND;
//   other pops go IDLE, FETCH (registered RAM read refreshes the end word), SEND.
// Flow: one op in flight, taken in IDLE only; SEND waits for a free output reg.
// Reset: synchronous; empties the deque, RAM contents are left as they are.
// ---------------------------------------------------------------------------
module circular_deque (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_stall,
   input  logic [1:0]                  req_func,
   input  logic signed [31:0]          req_value,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output logic [1:0]                  rsp_status,
   output logic [4:0]                  rsp_fill_count,
   output logic                        rsp_is_empty,
   output logic                        rsp_is_full,
   output logic signed [31:0]          rsp_front_word,
   output logic signed [31:0]          rsp_rear_word
);
   import cdq_pkg::*;

   cdq_mem_req_type   mem_req;
   logic [WORD_W-1:0] mem_rd_data;
   logic              res_valid;
   cdq_result_type    res;
   logic              res_free;
   cdq_result_type    rsp_beat;

   cdq_ram #(
      .WIDTH  (WORD_W),
      .DEPTH  (DEPTH),
      .ADDR_W (IDX_W)
   ) u_ram (
      .clock   (clock),
      .wr_en   (mem_req.wr_en),
      .wr_addr (mem_req.wr_addr),
      .wr_data (mem_req.wr_data),
      .rd_en   (mem_req.rd_en),
      .rd_addr (mem_req.rd_addr),
      .rd_data (mem_rd_data)
   );

   cdq_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_func    (req_func),
      .req_value   (req_value),
      .mem_req     (mem_req),
      .mem_rd_data (mem_rd_data),
      .res_valid   (res_valid),
      .res         (res),
      .res_free    (res_free)
   );

   cdq_out u_out (
      .clock     (clock),
      .reset     (reset),
      .res_valid (res_valid),
      .res       (res),
      .res_free  (res_free),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_beat  (rsp_beat)
   );

   assign rsp_status     = rsp_beat.status;
   assign rsp_fill_count = rsp_beat.fill_count;
   assign rsp_is_empty   = rsp_beat.is_empty;
   assign rsp_is_full    = rsp_beat.is_full;
   assign rsp_front_word = rsp_beat.front_word;
   assign rsp_rear_word  = rsp_beat.rear_word;

`ifndef SYNTH
   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> req_stall)
      else $error("second op accepted while one is in flight");

   a_flags_exclusive: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_is_empty && rsp_is_full))
      else $error("deque reported empty and full together");

   a_overflow_full: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status == ST_OVERFLOW) |-> rsp_is_full)
      else $error("overflow reported on a deque that is not full");

   a_underflow_empty: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status == ST_UNDERFLOW) |-> rsp_is_empty)
      else $error("underflow reported on a deque that is not empty");

   a_no_ram_conflict: assert property (@(posedge clock) disable iff (reset)
      !(mem_req.wr_en && mem_req.rd_en))
      else $error("ring RAM written and read in the same cycle");
`endif

endmodule
